FILE: sv/som_ts_pkg.sv
package som_ts_pkg;

  localparam int REG_W     = 24;
  localparam int STEP_W    = 20;
  localparam int DIST_W    = 22;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 24;
  localparam int SCALE_W   = 17;
  localparam int QUO_W     = 16;
  localparam int FRAC_SH   = 40;

  localparam logic [REG_W-1:0] RST_INIT_RATE    = 24'd1677722;
  localparam logic [REG_W-1:0] RST_INIT_RADIUS  = 24'd5242880;
  localparam logic [REG_W-1:0] RST_RATE_DECAY   = 24'd16776377;
  localparam logic [REG_W-1:0] RST_RADIUS_DECAY = 24'd16775866;
  localparam logic [STEP_W-1:0] STEP_MAX        = '1;
  localparam logic [SCALE_W-1:0] SCALE_ONE      = 17'd65536;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRAIN = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_RATE    = 2'd0,
    CFG_INIT_RADIUS  = 2'd1,
    CFG_RATE_DECAY   = 2'd2,
    CFG_RADIUS_DECAY = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIN,
    ST_SC_RD,
    ST_SC_X,
    ST_SC_Y,
    ST_SC_Z,
    ST_SC_CMP,
    ST_R2,
    ST_UP_CHK,
    ST_UP_DIV,
    ST_UP_EXP,
    ST_UP_GAIN,
    ST_UP_MX,
    ST_UP_MY,
    ST_UP_MZ,
    ST_DEC_RATE,
    ST_DEC_RAD
  } st_e;

  typedef logic [REG_W-1:0] reg_t;

  // exp(-k/32) in Q1.16 for k up to 16; larger k give the k = 16 entry
  function automatic logic [SCALE_W-1:0] exp_tab(input logic [4:0] k);
    logic [SCALE_W-1:0] t;
    case (k)
      5'd0:    t = 17'd65536;
      5'd1:    t = 17'd63520;
      5'd2:    t = 17'd61565;
      5'd3:    t = 17'd59671;
      5'd4:    t = 17'd57835;
      5'd5:    t = 17'd56056;
      5'd6:    t = 17'd54331;
      5'd7:    t = 17'd52660;
      5'd8:    t = 17'd51039;
      5'd9:    t = 17'd49469;
      5'd10:   t = 17'd47947;
      5'd11:   t = 17'd46472;
      5'd12:   t = 17'd45042;
      5'd13:   t = 17'd43656;
      5'd14:   t = 17'd42313;
      5'd15:   t = 17'd41011;
      default: t = 17'd39750;
    endcase
    return t;
  endfunction

endpackage

FILE: sv/som_ts_if.sv
interface som_ts_in_if #(
  parameter int UB = 5,
  parameter int VB = 5,
  parameter int CB = 10
);
  logic          valid;
  logic          ready;
  logic [1:0]    operation;
  logic [UB-1:0] cell_u;
  logic [VB-1:0] cell_v;
  logic [CB-1:0] sample_x;
  logic [CB-1:0] sample_y;
  logic [CB-1:0] sample_z;

  modport source (output valid, operation, cell_u, cell_v, sample_x, sample_y, sample_z,
                  input ready);
  modport sink (input valid, operation, cell_u, cell_v, sample_x, sample_y, sample_z,
                output ready);
endinterface

interface som_ts_out_if #(
  parameter int UB = 5,
  parameter int VB = 5,
  parameter int WB = 18
);
  logic                             valid;
  logic                             ready;
  logic [UB-1:0]                    winner_u;
  logic [VB-1:0]                    winner_v;
  logic [som_ts_pkg::DIST_W-1:0]    winner_distance;
  logic [WB-1:0]                    weight_x;
  logic [WB-1:0]                    weight_y;
  logic [WB-1:0]                    weight_z;
  logic [som_ts_pkg::STEP_W-1:0]    steps_done;

  modport source (output valid, winner_u, winner_v, winner_distance, weight_x, weight_y,
                  weight_z, steps_done, input ready);
  modport sink (input valid, winner_u, winner_v, winner_distance, weight_x, weight_y,
                weight_z, steps_done, output ready);
endinterface

interface som_ts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [som_ts_pkg::CFG_IDX_W-1:0]  index;
  logic [som_ts_pkg::REG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/som_train_step_unit.sv
// Kohonen map of GRID_WIDTH x GRID_HEIGHT nodes, three Q10.8 weights each, held in
// three single-port memories. One item is taken at a time; in_i.ready is high only
// when the block is idle. Every item but train goes from idle straight to the finish
// state. Train first scans every node with one shared 24x24 multiplier, one weight
// lane at a time, then walks the grid again; a node within the radius goes through
// the exponent division, the gain and three moves, while the winner skips the division.
// With the reset settings the radius is 5, so at most 81 nodes move, the winner among
// them. The weights are undefined until loaded. Config writes are always taken and
// must be made while idle; writing the initial rate or radius also reloads the current
// value.
module som_train_step_unit #(
  parameter int GRID_WIDTH  = 20,
  parameter int GRID_HEIGHT = 20,
  parameter int COORD_BITS  = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  som_ts_in_if.sink     in_i,
  som_ts_out_if.source  out_o,
  som_ts_cfg_if.sink    cfg_i
);
  import som_ts_pkg::*;

  localparam int NODES  = GRID_WIDTH * GRID_HEIGHT;
  localparam int NB     = $clog2(NODES);
  localparam int UB     = $clog2(GRID_WIDTH);
  localparam int VB     = $clog2(GRID_HEIGHT);
  localparam int WB     = COORD_BITS + 8;
  localparam int DW     = 2 * WB + 2;
  localparam int G2W    = $clog2((GRID_WIDTH - 1) ** 2 + (GRID_HEIGHT - 1) ** 2 + 1);
  localparam int NUM_W  = G2W + FRAC_SH;
  localparam int R2_W   = 2 * REG_W;
  localparam int CMP_W  = ((NUM_W > R2_W) ? NUM_W : R2_W) + 2;

  logic [WB-1:0] mem_x [NODES];
  logic [WB-1:0] mem_y [NODES];
  logic [WB-1:0] mem_z [NODES];
  logic [WB-1:0] rd_x_q, rd_y_q, rd_z_q;

  st_e state_q, state_d;
  op_e op_q;
  logic [NB-1:0] idx_q, n_q, bn_q;
  logic [UB-1:0] u_q, bu_q;
  logic [VB-1:0] v_q, bv_q;
  logic in_grid_q, first_q;
  logic [WB-1:0] sx_q, sy_q, sz_q, nx_q, ny_q;
  logic [DW-1:0] acc_q, best_q;
  logic [R2_W-1:0] r2_q;
  logic [CMP_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [3:0] cnt_q;
  logic [SCALE_W-1:0] scale_q;
  reg_t gain_q, rate_q, radius_q, init_rate_q, init_radius_q, rate_dec_q, radius_dec_q;
  logic [STEP_W-1:0] step_q;
  logic ov_q;

  // shared multiplier
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [NB-1:0] addr_c, in_idx;
  logic in_grid_c, in_acc, last_n, last_v, ge, in_nb;
  logic [WB-1:0] sel_w, sel_s, dlt, mv, moved;
  logic [UB-1:0] du;
  logic [VB-1:0] dv;
  logic [G2W-1:0] d2g;
  logic [CMP_W-1:0] num_c, r2_ext, rem_sub;
  logic [SCALE_W-1:0] t0, t1, scale_c;
  logic [DW-1:0] dist_pad;
  logic [UB-1:0] res_u;
  logic [VB-1:0] res_v;
  logic [DIST_W-1:0] res_dist;
  logic [WB-1:0] res_x, res_y, res_z;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_grid_c = (32'(in_i.cell_u) < GRID_WIDTH) && (32'(in_i.cell_v) < GRID_HEIGHT);
  assign in_idx    = NB'(NB'(in_i.cell_u) * NB'(GRID_HEIGHT) + NB'(in_i.cell_v));
  assign last_n    = (n_q == NB'(NODES - 1));
  assign last_v    = (v_q == VB'(GRID_HEIGHT - 1));

  // coordinate lane picked by the sequencer
  always_comb begin
    case (state_q)
      ST_SC_Y, ST_UP_MY: begin
        sel_w = rd_y_q;
        sel_s = sy_q;
      end
      ST_SC_Z, ST_UP_MZ: begin
        sel_w = rd_z_q;
        sel_s = sz_q;
      end
      default: begin
        sel_w = rd_x_q;
        sel_s = sx_q;
      end
    endcase
  end

  assign dlt   = (sel_s >= sel_w) ? (sel_s - sel_w) : (sel_w - sel_s);
  assign mv    = WB'(mul_p >> 24);
  assign moved = (sel_s >= sel_w) ? (sel_w + mv) : (sel_w - mv);

  assign du     = (u_q >= bu_q) ? (u_q - bu_q) : (bu_q - u_q);
  assign dv     = (v_q >= bv_q) ? (v_q - bv_q) : (bv_q - v_q);
  assign d2g    = G2W'(G2W'(du) * G2W'(du) + G2W'(dv) * G2W'(dv));
  assign num_c  = CMP_W'(d2g) << FRAC_SH;
  assign r2_ext = CMP_W'(r2_q);
  assign in_nb  = (num_c <= r2_ext);

  assign ge      = (rem_q >= r2_ext);
  assign rem_sub = ge ? (rem_q - r2_ext) : rem_q;

  assign t0 = exp_tab({1'b0, quo_q[14:11]});
  assign t1 = exp_tab(5'({1'b0, quo_q[14:11]} + 5'd1));
  assign scale_c = quo_q[15] ? exp_tab(5'd16) : (t0 - SCALE_W'(mul_p >> 11));

  assign dist_pad = best_q >> 16;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_e'(in_i.operation) == OP_TRAIN) ? ST_SC_RD : ST_FIN;
        end
      end
      ST_SC_RD:  state_d = ST_SC_X;
      ST_SC_X:   state_d = ST_SC_Y;
      ST_SC_Y:   state_d = ST_SC_Z;
      ST_SC_Z:   state_d = ST_SC_CMP;
      ST_SC_CMP: state_d = last_n ? ST_R2 : ST_SC_X;
      ST_R2:     state_d = ST_UP_CHK;
      ST_UP_CHK: begin
        if (!in_nb) begin
          state_d = last_n ? ST_DEC_RATE : ST_UP_CHK;
        end else if (d2g == '0) begin
          state_d = ST_UP_GAIN;
        end else begin
          state_d = ST_UP_DIV;
        end
      end
      ST_UP_DIV:   state_d = (cnt_q == '0) ? ST_UP_EXP : ST_UP_DIV;
      ST_UP_EXP:   state_d = ST_UP_GAIN;
      ST_UP_GAIN:  state_d = ST_UP_MX;
      ST_UP_MX:    state_d = ST_UP_MY;
      ST_UP_MY:    state_d = ST_UP_MZ;
      ST_UP_MZ:    state_d = last_n ? ST_DEC_RATE : ST_UP_CHK;
      ST_DEC_RATE: state_d = ST_DEC_RAD;
      ST_DEC_RAD:  state_d = ST_FIN;
      ST_FIN:      state_d = (!ov_q || out_o.ready) ? ST_IDLE : ST_FIN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addr_c = n_q;
    case (state_q)
      ST_IDLE:   addr_c = in_grid_c ? in_idx : '0;
      ST_SC_X, ST_SC_Y, ST_SC_Z: begin
        mul_a = MUL_W'(dlt);
        mul_b = MUL_W'(dlt);
      end
      ST_SC_CMP: addr_c = last_n ? n_q : NB'(n_q + 1'b1);
      ST_R2: begin
        mul_a = radius_q;
        mul_b = radius_q;
      end
      ST_UP_EXP: begin
        mul_a = MUL_W'(t0 - t1);
        mul_b = MUL_W'(quo_q[10:0]);
      end
      ST_UP_GAIN: begin
        mul_a = rate_q;
        mul_b = MUL_W'(scale_q);
      end
      ST_UP_MX, ST_UP_MY, ST_UP_MZ: begin
        mul_a = MUL_W'(dlt);
        mul_b = gain_q;
      end
      ST_DEC_RATE: begin
        mul_a = rate_q;
        mul_b = rate_dec_q;
      end
      ST_DEC_RAD: begin
        mul_a  = radius_q;
        mul_b  = radius_dec_q;
        addr_c = bn_q;
      end
      ST_FIN:  addr_c = (op_q == OP_TRAIN) ? bn_q : idx_q;
      default: addr_c = n_q;
    endcase
  end

  // weight memories
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && op_e'(in_i.operation) == OP_LOAD && in_grid_c) begin
      mem_x[in_idx] <= {in_i.sample_x, 8'd0};
      mem_y[in_idx] <= {in_i.sample_y, 8'd0};
      mem_z[in_idx] <= {in_i.sample_z, 8'd0};
    end else if (state_q == ST_UP_MZ) begin
      mem_x[n_q] <= nx_q;
      mem_y[n_q] <= ny_q;
      mem_z[n_q] <= moved;
    end
    rd_x_q <= mem_x[addr_c];
    rd_y_q <= mem_y[addr_c];
    rd_z_q <= mem_z[addr_c];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ov_q          <= 1'b0;
      step_q        <= '0;
      init_rate_q   <= RST_INIT_RATE;
      init_radius_q <= RST_INIT_RADIUS;
      rate_dec_q    <= RST_RATE_DECAY;
      radius_dec_q  <= RST_RADIUS_DECAY;
      rate_q        <= RST_INIT_RATE;
      radius_q      <= RST_INIT_RADIUS;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && (!ov_q || out_o.ready)) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (state_q == ST_DEC_RATE) begin
        rate_q <= mul_p[47:24];
      end
      if (state_q == ST_DEC_RAD) begin
        radius_q <= mul_p[47:24];
        if (step_q != STEP_MAX) begin
          step_q <= step_q + 1'b1;
        end
      end
      if (cfg_i.valid) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_INIT_RATE: begin
            init_rate_q <= cfg_i.data;
            rate_q      <= cfg_i.data;
          end
          CFG_INIT_RADIUS: begin
            init_radius_q <= cfg_i.data;
            radius_q      <= cfg_i.data;
          end
          CFG_RATE_DECAY:   rate_dec_q   <= cfg_i.data;
          CFG_RADIUS_DECAY: radius_dec_q <= cfg_i.data;
          default:          rate_dec_q   <= rate_dec_q;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q      <= op_e'(in_i.operation);
          idx_q     <= in_grid_c ? in_idx : '0;
          in_grid_q <= in_grid_c;
          sx_q      <= {in_i.sample_x, 8'd0};
          sy_q      <= {in_i.sample_y, 8'd0};
          sz_q      <= {in_i.sample_z, 8'd0};
          u_q       <= '0;
          v_q       <= '0;
          n_q       <= '0;
          first_q   <= 1'b1;
        end
      end
      ST_SC_X: acc_q <= DW'(mul_p);
      ST_SC_Y, ST_SC_Z: acc_q <= acc_q + DW'(mul_p);
      ST_SC_CMP: begin
        first_q <= 1'b0;
        if (first_q || acc_q < best_q) begin
          best_q <= acc_q;
          bu_q   <= u_q;
          bv_q   <= v_q;
          bn_q   <= n_q;
        end
        u_q <= last_v ? UB'(u_q + 1'b1) : u_q;
        v_q <= last_v ? '0 : VB'(v_q + 1'b1);
        n_q <= NB'(n_q + 1'b1);
      end
      ST_R2: begin
        r2_q <= R2_W'(mul_p);
        u_q  <= '0;
        v_q  <= '0;
        n_q  <= '0;
      end
      ST_UP_CHK: begin
        rem_q   <= num_c;
        cnt_q   <= 4'd15;
        quo_q   <= '0;
        scale_q <= SCALE_ONE;
        if (!in_nb) begin
          u_q <= last_v ? UB'(u_q + 1'b1) : u_q;
          v_q <= last_v ? '0 : VB'(v_q + 1'b1);
          n_q <= NB'(n_q + 1'b1);
        end
      end
      ST_UP_DIV: begin
        quo_q[cnt_q] <= ge;
        rem_q        <= rem_sub << 1;
        cnt_q        <= cnt_q - 1'b1;
      end
      ST_UP_EXP:  scale_q <= scale_c;
      ST_UP_GAIN: gain_q  <= mul_p[39:16];
      ST_UP_MX:   nx_q    <= moved;
      ST_UP_MY:   ny_q    <= moved;
      ST_UP_MZ: begin
        u_q <= last_v ? UB'(u_q + 1'b1) : u_q;
        v_q <= last_v ? '0 : VB'(v_q + 1'b1);
        n_q <= NB'(n_q + 1'b1);
      end
      default: acc_q <= acc_q;
    endcase
  end

  // result fields for the finished item
  always_comb begin
    res_u    = '0;
    res_v    = '0;
    res_dist = '0;
    res_x    = '0;
    res_y    = '0;
    res_z    = '0;
    case (op_q)
      OP_TRAIN: begin
        res_u    = bu_q;
        res_v    = bv_q;
        res_dist = DIST_W'(dist_pad);
        res_x    = rd_x_q;
        res_y    = rd_y_q;
        res_z    = rd_z_q;
      end
      OP_LOAD: begin
        if (in_grid_q) begin
          res_x = sx_q;
          res_y = sy_q;
          res_z = sz_q;
        end
      end
      OP_READ: begin
        if (in_grid_q) begin
          res_x = rd_x_q;
          res_y = rd_y_q;
          res_z = rd_z_q;
        end
      end
      default: res_dist = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && (!ov_q || out_o.ready)) begin
      out_o.winner_u        <= res_u;
      out_o.winner_v        <= res_v;
      out_o.winner_distance <= res_dist;
      out_o.weight_x        <= res_x;
      out_o.weight_y        <= res_y;
      out_o.weight_z        <= res_z;
      out_o.steps_done      <= step_q;
    end
  end

  assign out_o.valid = ov_q;

endmodule

FILE: sv/som_ts_chk.sv
module som_ts_chk #(
  parameter int GRID_WIDTH  = 20,
  parameter int GRID_HEIGHT = 20,
  parameter int UB          = 5,
  parameter int VB          = 5
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [UB-1:0]                    winner_u_i,
  input logic [VB-1:0]                    winner_v_i,
  input logic [som_ts_pkg::STEP_W-1:0]    steps_done_i
);

  // one item at a time: busy right after a beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_win_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(winner_u_i) < GRID_WIDTH) && (32'(winner_v_i) < GRID_HEIGHT))
    else $error("winner outside grid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(winner_u_i) && $stable(winner_v_i) && $stable(steps_done_i))
    else $error("stalled result changed");

endmodule

bind som_train_step_unit som_ts_chk #(
  .GRID_WIDTH  (GRID_WIDTH),
  .GRID_HEIGHT (GRID_HEIGHT),
  .UB          ($clog2(GRID_WIDTH)),
  .VB          ($clog2(GRID_HEIGHT))
) u_som_ts_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .winner_u_i   (out_o.winner_u),
  .winner_v_i   (out_o.winner_v),
  .steps_done_i (out_o.steps_done)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import som_ts_pkg::*;

  localparam int GW    = 20;
  localparam int GH    = 20;
  localparam int NODES = GW * GH;

  typedef struct {
    op_e        op;
    logic [4:0] u;
    logic [4:0] v;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] z;
  } cmd_t;

  typedef struct {
    logic [4:0]        wu;
    logic [4:0]        wv;
    logic [DIST_W-1:0] wdist;
    logic [17:0]       wx;
    logic [17:0]       wy;
    logic [17:0]       wz;
    logic [STEP_W-1:0] steps;
  } node_res_t;

  typedef struct {
    cmd_t      c;
    bit        typed;
    node_res_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  som_ts_in_if  in_if ();
  som_ts_out_if out_if ();
  som_ts_cfg_if cfg_if ();

  som_train_step_unit #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH), .COORD_BITS(10)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // map mirror
  bit [17:0]       map_x [NODES];
  bit [17:0]       map_y [NODES];
  bit [17:0]       map_z [NODES];
  bit [REG_W-1:0]  rate_now, radius_now, rate_decay, radius_decay;
  bit [STEP_W-1:0] step_cnt;
  bit [16:0]       exp_lut [17] = '{65536, 63520, 61565, 59671, 57835, 56056, 54331, 52660,
                                    51039, 49469, 47947, 46472, 45042, 43656, 42313, 41011,
                                    39750};

  node_res_t pending_res[$];
  int        err_cnt = 0;
  bit        idle_on = 1'b1;
  bit        long_hold = 1'b0;

  function automatic bit [17:0] pull_toward(bit [17:0] w, bit [17:0] t, bit [63:0] g);
    if (t >= w) return w + 18'(((64'(t) - w) * g) >> 24);
    return w - 18'(((64'(w) - t) * g) >> 24);
  endfunction

  function automatic bit [63:0] sq(bit [17:0] a, bit [17:0] b);
    bit [63:0] d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  function automatic node_res_t som_step(cmd_t c);
    node_res_t r;
    bit [17:0] sx, sy, sz;
    bit        on_grid;
    int        idx, best, bu, bv, du, dv, k;
    bit [63:0] d, bestd, r2, num, a, scale, gain;
    sx = {c.x, 8'd0};
    sy = {c.y, 8'd0};
    sz = {c.z, 8'd0};
    on_grid = (c.u < GW) && (c.v < GH);
    idx = c.u * GH + c.v;
    r = '{default: '0};
    case (c.op)
      OP_LOAD: if (on_grid) begin
        map_x[idx] = sx;
        map_y[idx] = sy;
        map_z[idx] = sz;
        r.wx = sx;
        r.wy = sy;
        r.wz = sz;
      end
      OP_READ: if (on_grid) begin
        r.wx = map_x[idx];
        r.wy = map_y[idx];
        r.wz = map_z[idx];
      end
      OP_TRAIN: begin
        best = 0;
        bestd = sq(map_x[0], sx) + sq(map_y[0], sy) + sq(map_z[0], sz);
        for (int n = 1; n < NODES; n++) begin
          d = sq(map_x[n], sx) + sq(map_y[n], sy) + sq(map_z[n], sz);
          if (d < bestd) begin
            bestd = d;
            best = n;
          end
        end
        bu = best / GH;
        bv = best % GH;
        r2 = 64'(radius_now) * radius_now;
        for (int i = 0; i < GW; i++) begin
          for (int j = 0; j < GH; j++) begin
            du = (i >= bu) ? i - bu : bu - i;
            dv = (j >= bv) ? j - bv : bv - j;
            num = 64'(du * du + dv * dv) << 40;
            if (num > r2) continue;
            if (r2 == 0) scale = 65536;
            else begin
              a = (num << 15) / r2;
              if (a >= 32768) scale = exp_lut[16];
              else scale = exp_lut[a >> 11] -
                           (((exp_lut[a >> 11] - exp_lut[(a >> 11) + 1]) * (a & 2047)) >> 11);
            end
            gain = (64'(rate_now) * scale) >> 16;
            k = i * GH + j;
            map_x[k] = pull_toward(map_x[k], sx, gain);
            map_y[k] = pull_toward(map_y[k], sy, gain);
            map_z[k] = pull_toward(map_z[k], sz, gain);
          end
        end
        rate_now = REG_W'((64'(rate_now) * rate_decay) >> 24);
        radius_now = REG_W'((64'(radius_now) * radius_decay) >> 24);
        if (step_cnt != STEP_MAX) step_cnt++;
        r.wu = 5'(bu);
        r.wv = 5'(bv);
        r.wdist = DIST_W'(bestd >> 16);
        r.wx = map_x[best];
        r.wy = map_y[best];
        r.wz = map_z[best];
      end
      default: ;
    endcase
    r.steps = step_cnt;
    return r;
  endfunction

  task automatic send_cmd(cmd_t c, bit typed = 1'b0, node_res_t want = '{default: '0});
    int gap;
    node_res_t r;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= c.op;
    in_if.cell_u    <= c.u;
    in_if.cell_v    <= c.v;
    in_if.sample_x  <= c.x;
    in_if.sample_y  <= c.y;
    in_if.sample_z  <= c.z;
    do @(posedge clk); while (!in_if.ready);
    r = som_step(c);
    pending_res.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [REG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INIT_RATE:   rate_now = val;
      CFG_INIT_RADIUS: radius_now = val;
      CFG_RATE_DECAY:  rate_decay = val;
      default:         radius_decay = val;
    endcase
  endtask

  function automatic logic [9:0] pick_coord();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return 10'd0;
    if (s == 1) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   s;
    s = $urandom_range(0, 99);
    c.op = (s < 40) ? OP_LOAD : (s < 75) ? OP_READ : (s < 90) ? OP_TRAIN : OP_NONE;
    if ($urandom_range(0, 9) == 0) begin
      c.u = 5'($urandom_range(0, 31));
      c.v = 5'($urandom_range(20, 31));
    end else begin
      c.u = 5'($urandom_range(0, GW - 1));
      c.v = 5'($urandom_range(0, GH - 1));
    end
    c.x = pick_coord();
    c.y = pick_coord();
    c.z = pick_coord();
    return c;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // result side
  initial begin
    int        stall;
    node_res_t e;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        stall = 2000;
        long_hold = 1'b0;
      end else stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = pending_res.pop_front();
        check_field("winner_u", e.wu, out_if.winner_u);
        check_field("winner_v", e.wv, out_if.winner_v);
        check_field("winner_distance", e.wdist, out_if.winner_distance);
        check_field("weight_x", e.wx, out_if.weight_x);
        check_field("weight_y", e.wy, out_if.weight_y);
        check_field("weight_z", e.wz, out_if.weight_z);
        check_field("steps_done", e.steps, out_if.steps_done);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    bit [REG_W-1:0] phase_regs [4][4] = '{
      '{24'd1677722, 24'd5242880, 24'd16776377, 24'd16775866},
      '{24'hFFFFFF,  24'd0,       24'hFFFFFF,   24'hFFFFFF},
      '{24'h400000,  24'hFFFFFF,  24'h800000,   24'hE00000},
      '{24'd0,       24'h100000,  24'd0,        24'd0}
    };
    node_res_t z, full;
    dir_row_t  rows [$];
    cmd_t      c;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_LOAD;
    in_if.cell_u = '0;
    in_if.cell_v = '0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    in_if.sample_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_INIT_RATE;
    cfg_if.data = '0;
    rate_now = RST_INIT_RATE;
    radius_now = RST_INIT_RADIUS;
    rate_decay = RST_RATE_DECAY;
    radius_decay = RST_RADIUS_DECAY;
    step_cnt = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole map first so no train or read touches an unwritten node
    for (int n = 0; n < NODES; n++) begin
      c = '{OP_LOAD, 5'(n / GH), 5'(n % GH), pick_coord(), pick_coord(), pick_coord()};
      send_cmd(c);
    end

    z = '{default: '0};
    full = z;
    full.wx = 18'h3FF00;
    full.wy = 18'h3FF00;
    full.wz = 18'h3FF00;
    rows = '{
      '{'{OP_READ, 5'd20, 5'd0, 10'd0, 10'd0, 10'd0}, 1'b1, z},
      '{'{OP_READ, 5'd31, 5'd31, 10'd1023, 10'd1023, 10'd1023}, 1'b1, z},
      '{'{OP_LOAD, 5'd25, 5'd3, 10'd1023, 10'd512, 10'd7}, 1'b1, z},
      '{'{OP_NONE, 5'd31, 5'd31, 10'd1023, 10'd1023, 10'd1023}, 1'b1, z},
      '{'{OP_LOAD, 5'd0, 5'd0, 10'd1023, 10'd1023, 10'd1023}, 1'b1, full},
      '{'{OP_LOAD, 5'd19, 5'd19, 10'd0, 10'd0, 10'd0}, 1'b1, z},
      '{'{OP_READ, 5'd0, 5'd0, 10'd0, 10'd0, 10'd0}, 1'b1, full},
      '{'{OP_TRAIN, 5'd0, 5'd0, 10'd0, 10'd0, 10'd0}, 1'b0, z},
      '{'{OP_TRAIN, 5'd31, 5'd31, 10'd1023, 10'd1023, 10'd1023}, 1'b0, z},
      '{'{OP_TRAIN, 5'd0, 5'd0, 10'd512, 10'd300, 10'd700}, 1'b0, z},
      '{'{OP_READ, 5'd19, 5'd19, 10'd0, 10'd0, 10'd0}, 1'b0, z},
      '{'{OP_READ, 5'd0, 5'd0, 10'd0, 10'd0, 10'd0}, 1'b0, z},
      '{'{OP_LOAD, 5'd10, 5'd10, 10'd341, 10'd682, 10'd1}, 1'b0, z},
      '{'{OP_TRAIN, 5'd10, 5'd10, 10'd341, 10'd682, 10'd1}, 1'b0, z},
      '{'{OP_READ, 5'd10, 5'd11, 10'd0, 10'd0, 10'd0}, 1'b0, z}
    };
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].r);
    drain();

    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r < 4; r++) write_reg(cfg_idx_e'(r), phase_regs[p][r]);
      idle_on = (p != 2);
      for (int n = 0; n < 70; n++) begin
        if (p == 0 && n == 20) long_hold = 1'b1;
        if (p == 1 && n == 40) drain();
        send_cmd(rand_cmd());
      end
      drain();
    end

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
